/* rtl/core/fcsr_pkg.sv */
// Shared types, widths and result codes for the filled circle span rasterizer.
// Used by the front end, the job queue, the back end, the top level, the checker and the bench.
package fcsr_pkg;

  localparam int SCREEN_WIDTH_DEF  = 160;
  localparam int SCREEN_HEIGHT_DEF = 80;

  localparam int COORD_W     = 10;
  localparam int CLIP_W      = 11;
  localparam int DEC_W       = 12;
  localparam int NUM_SLOTS   = 4;
  localparam int SLOT_W      = $clog2(NUM_SLOTS);
  localparam int QUEUE_DEPTH = 2;

  localparam logic [2:0] KIND_SPAN     = 3'd0;
  localparam logic [2:0] KIND_NONE     = 3'd1;
  localparam logic [2:0] KIND_DONE     = 3'd2;
  localparam logic [2:0] KIND_STARTED  = 3'd3;
  localparam logic [2:0] KIND_REJECTED = 3'd4;

  localparam logic ACT_START = 1'b0;
  localparam logic ACT_STEP  = 1'b1;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t h;
  } span_raw_t;

  typedef struct packed {
    logic                           is_span;
    logic [2:0]                     kind;
    logic [NUM_SLOTS-1:0]           slot_en;
    span_raw_t [NUM_SLOTS-1:0]      spans;
    logic [15:0]                    color;
  } job_t;

  typedef struct packed {
    logic       vis;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] h;
  } span_clip_t;

endpackage

/* rtl/core/fcsr_ifs.sv */
// Valid/ready channel interfaces for command items in and span result items out.
// Depends on nothing.
interface fcsr_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [7:0]  center_x;
  logic [7:0]  center_y;
  logic [7:0]  radius;
  logic [15:0] fill_color;

  modport source (output valid, action, center_x, center_y, radius, fill_color,
                  input ready);
  modport sink   (input valid, action, center_x, center_y, radius, fill_color,
                  output ready);
endinterface

interface fcsr_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [7:0]  span_x;
  logic [7:0]  span_y;
  logic [7:0]  span_height;
  logic [15:0] span_color;
  logic        last;

  modport source (output valid, kind, span_x, span_y, span_height, span_color, last,
                  input ready);
  modport sink   (input valid, kind, span_x, span_y, span_height, span_color, last,
                  output ready);
endinterface

/* rtl/core/fcsr_front.sv */
// Front end: accepts command items, runs the midpoint circle walk state and
// builds one job per item for the queue. Depends on fcsr_pkg and fcsr_in_if.
module fcsr_front (
  input  logic           clk,
  input  logic           rst_n,
  fcsr_in_if.sink        in_chan,
  input  logic           q_full,
  output logic           push,
  output fcsr_pkg::job_t job
);

  logic                          active_r, active_nxt;
  logic                          first_done_r, first_done_nxt;
  logic [7:0]                    ctr_x_r, ctr_x_nxt;
  logic [7:0]                    ctr_y_r, ctr_y_nxt;
  logic [7:0]                    rad_r, rad_nxt;
  logic [15:0]                   color_held_r, color_held_nxt;
  logic [7:0]                    pos_x_r, pos_x_nxt;
  logic [7:0]                    pos_y_r, pos_y_nxt;
  logic [fcsr_pkg::DEC_W-1:0]    decision_r, decision_nxt;

  logic                          accept;
  logic [fcsr_pkg::DEC_W-1:0]    two_x, two_y, dec_step;
  logic [7:0]                    x_new, y_new;
  fcsr_pkg::coord_t              cxs, cys, xs, ys, h_y, h_x, h_r;

  assign in_chan.ready = !q_full;
  assign accept        = in_chan.valid && in_chan.ready;
  assign push          = accept;

  always_comb begin
    two_x = fcsr_pkg::DEC_W'({pos_x_r, 1'b0});
    two_y = fcsr_pkg::DEC_W'({pos_y_r, 1'b0});
    x_new = pos_x_r + 8'd1;
    if (decision_r[fcsr_pkg::DEC_W-1]) begin
      dec_step = decision_r + two_x + fcsr_pkg::DEC_W'(3);
      y_new    = pos_y_r;
    end else begin
      dec_step = decision_r + two_x - two_y + fcsr_pkg::DEC_W'(5);
      y_new    = pos_y_r - 8'd1;
    end
    cxs = fcsr_pkg::coord_t'(fcsr_pkg::COORD_W'(ctr_x_r));
    cys = fcsr_pkg::coord_t'(fcsr_pkg::COORD_W'(ctr_y_r));
    xs  = fcsr_pkg::coord_t'(fcsr_pkg::COORD_W'(x_new));
    ys  = fcsr_pkg::coord_t'(fcsr_pkg::COORD_W'(y_new));
    h_y = fcsr_pkg::coord_t'({1'b0, y_new, 1'b1});
    h_x = fcsr_pkg::coord_t'({1'b0, x_new, 1'b1});
    h_r = fcsr_pkg::coord_t'({1'b0, rad_r, 1'b1});
  end

  always_comb begin
    active_nxt     = active_r;
    first_done_nxt = first_done_r;
    ctr_x_nxt      = ctr_x_r;
    ctr_y_nxt      = ctr_y_r;
    rad_nxt        = rad_r;
    color_held_nxt = color_held_r;
    pos_x_nxt      = pos_x_r;
    pos_y_nxt      = pos_y_r;
    decision_nxt   = decision_r;

    job         = '0;
    job.kind    = fcsr_pkg::KIND_DONE;
    job.color   = color_held_r;

    if (in_chan.action == fcsr_pkg::ACT_START) begin
      if (in_chan.radius == 8'd0) begin
        job.kind = fcsr_pkg::KIND_REJECTED;
      end else begin
        job.kind = fcsr_pkg::KIND_STARTED;
        if (accept) begin
          ctr_x_nxt      = in_chan.center_x;
          ctr_y_nxt      = in_chan.center_y;
          rad_nxt        = in_chan.radius;
          color_held_nxt = in_chan.fill_color;
          pos_x_nxt      = 8'd0;
          pos_y_nxt      = in_chan.radius;
          decision_nxt   = fcsr_pkg::DEC_W'(1) - fcsr_pkg::DEC_W'(in_chan.radius);
          active_nxt     = 1'b1;
          first_done_nxt = 1'b0;
        end
      end
    end else if (!active_r) begin
      job.kind = fcsr_pkg::KIND_DONE;
    end else if (!first_done_r) begin
      job.is_span    = 1'b1;
      job.kind       = fcsr_pkg::KIND_NONE;
      job.slot_en    = fcsr_pkg::NUM_SLOTS'(1);
      job.spans[0].x = cxs;
      job.spans[0].y = cys - fcsr_pkg::coord_t'(fcsr_pkg::COORD_W'(rad_r));
      job.spans[0].h = h_r;
      if (accept) begin
        first_done_nxt = 1'b1;
      end
    end else if (pos_x_r >= pos_y_r) begin
      job.kind = fcsr_pkg::KIND_DONE;
      if (accept) begin
        active_nxt = 1'b0;
      end
    end else begin
      job.is_span    = 1'b1;
      job.kind       = fcsr_pkg::KIND_NONE;
      job.slot_en    = '1;
      job.spans[0].x = cxs + xs;
      job.spans[0].y = cys - ys;
      job.spans[0].h = h_y;
      job.spans[1].x = cxs - xs;
      job.spans[1].y = cys - ys;
      job.spans[1].h = h_y;
      job.spans[2].x = cxs + ys;
      job.spans[2].y = cys - xs;
      job.spans[2].h = h_x;
      job.spans[3].x = cxs - ys;
      job.spans[3].y = cys - xs;
      job.spans[3].h = h_x;
      if (accept) begin
        pos_x_nxt    = x_new;
        pos_y_nxt    = y_new;
        decision_nxt = dec_step;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r     <= 1'b0;
      first_done_r <= 1'b0;
    end else begin
      active_r     <= active_nxt;
      first_done_r <= first_done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ctr_x_r      <= ctr_x_nxt;
    ctr_y_r      <= ctr_y_nxt;
    rad_r        <= rad_nxt;
    color_held_r <= color_held_nxt;
    pos_x_r      <= pos_x_nxt;
    pos_y_r      <= pos_y_nxt;
    decision_r   <= decision_nxt;
  end

endmodule

/* rtl/core/fcsr_queue.sv */
// Short job queue between front end and back end.
// Depends on fcsr_pkg.
module fcsr_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  fcsr_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output fcsr_pkg::job_t head_job
);

  localparam int PTR_W = (fcsr_pkg::QUEUE_DEPTH > 1) ? $clog2(fcsr_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(fcsr_pkg::QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(fcsr_pkg::QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(fcsr_pkg::QUEUE_DEPTH);

  fcsr_pkg::job_t          mem_r [fcsr_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]        wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]        rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic                    do_push, do_pop;

  assign full       = (count_r == DEPTH_C);
  assign head_valid = (count_r != '0);
  assign head_job   = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

/* rtl/core/fcsr_back.sv */
// Back end: clips the spans of one job, then sends its results one per cycle
// through the output register while the receiver is ready. Depends on fcsr_pkg and fcsr_out_if.
module fcsr_back #(
  parameter int SCREEN_WIDTH  = fcsr_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = fcsr_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           job_valid,
  input  fcsr_pkg::job_t job,
  output logic           pop,
  fcsr_out_if.source     out_chan
);

  localparam int CW = fcsr_pkg::CLIP_W;
  localparam int NS = fcsr_pkg::NUM_SLOTS;
  localparam logic signed [CW-1:0] W_C = CW'(SCREEN_WIDTH);
  localparam logic signed [CW-1:0] H_C = CW'(SCREEN_HEIGHT);

  function automatic fcsr_pkg::span_clip_t clip_span(fcsr_pkg::span_raw_t s);
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] h;
    fcsr_pkg::span_clip_t c;
    x = {s.x[fcsr_pkg::COORD_W-1], s.x};
    y = {s.y[fcsr_pkg::COORD_W-1], s.y};
    h = {s.h[fcsr_pkg::COORD_W-1], s.h};
    c.vis = 1'b1;
    if (h <= 0) c.vis = 1'b0;
    if (x < 0 || x >= W_C) c.vis = 1'b0;
    if (y < 0) begin
      h = h + y;
      y = '0;
    end
    if (y >= H_C) c.vis = 1'b0;
    if (y + h > H_C) h = H_C - y;
    if (h <= 0) c.vis = 1'b0;
    c.x = x[7:0];
    c.y = y[7:0];
    c.h = h[7:0];
    return c;
  endfunction

  logic                        work_valid_r, work_valid_nxt;
  logic [NS-1:0]               work_mask_r, work_mask_nxt;
  logic [2:0]                  work_kind_r, work_kind_nxt;
  fcsr_pkg::span_clip_t [NS-1:0] work_spans_r, work_spans_nxt;
  logic [15:0]                 work_color_r, work_color_nxt;

  logic                        out_valid_r, out_valid_nxt;
  logic [2:0]                  out_kind_r, out_kind_nxt;
  logic [7:0]                  out_x_r, out_x_nxt;
  logic [7:0]                  out_y_r, out_y_nxt;
  logic [7:0]                  out_h_r, out_h_nxt;
  logic [15:0]                 out_color_r, out_color_nxt;
  logic                        out_last_r, out_last_nxt;

  logic                        out_load, emit, work_done;
  logic [NS-1:0]               mask_rest, vis_mask;
  logic [fcsr_pkg::SLOT_W-1:0] sel;
  fcsr_pkg::span_clip_t [NS-1:0] clipped;

  assign out_load  = !out_valid_r || out_chan.ready;
  assign emit      = work_valid_r && out_load;
  assign mask_rest = work_mask_r & (work_mask_r - NS'(1));
  assign work_done = (mask_rest == '0);
  assign pop       = job_valid && (!work_valid_r || (emit && work_done));

  always_comb begin
    sel = '0;
    for (int i = NS - 1; i >= 0; i--) begin
      if (work_mask_r[i]) sel = fcsr_pkg::SLOT_W'(i);
    end
    for (int i = 0; i < NS; i++) begin
      clipped[i]  = clip_span(job.spans[i]);
      vis_mask[i] = clipped[i].vis;
    end
  end

  always_comb begin
    work_valid_nxt = work_valid_r;
    work_mask_nxt  = work_mask_r;
    work_kind_nxt  = work_kind_r;
    work_spans_nxt = work_spans_r;
    work_color_nxt = work_color_r;
    out_valid_nxt  = out_valid_r;
    out_kind_nxt   = out_kind_r;
    out_x_nxt      = out_x_r;
    out_y_nxt      = out_y_r;
    out_h_nxt      = out_h_r;
    out_color_nxt  = out_color_r;
    out_last_nxt   = out_last_r;

    if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    if (emit) begin
      out_valid_nxt = 1'b1;
      out_last_nxt  = work_done;
      if (work_mask_r == '0) begin
        out_kind_nxt  = work_kind_r;
        out_x_nxt     = 8'd0;
        out_y_nxt     = 8'd0;
        out_h_nxt     = 8'd0;
        out_color_nxt = 16'd0;
      end else begin
        out_kind_nxt  = fcsr_pkg::KIND_SPAN;
        out_x_nxt     = work_spans_r[sel].x;
        out_y_nxt     = work_spans_r[sel].y;
        out_h_nxt     = work_spans_r[sel].h;
        out_color_nxt = work_color_r;
      end
      work_mask_nxt = mask_rest;
      if (work_done) begin
        work_valid_nxt = 1'b0;
      end
    end

    if (pop) begin
      work_valid_nxt = 1'b1;
      work_kind_nxt  = job.kind;
      work_spans_nxt = clipped;
      work_color_nxt = job.color;
      work_mask_nxt  = job.is_span ? (vis_mask & job.slot_en) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      work_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      work_valid_r <= work_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    work_mask_r  <= work_mask_nxt;
    work_kind_r  <= work_kind_nxt;
    work_spans_r <= work_spans_nxt;
    work_color_r <= work_color_nxt;
    out_kind_r   <= out_kind_nxt;
    out_x_r      <= out_x_nxt;
    out_y_r      <= out_y_nxt;
    out_h_r      <= out_h_nxt;
    out_color_r  <= out_color_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.kind        = out_kind_r;
  assign out_chan.span_x      = out_x_r;
  assign out_chan.span_y      = out_y_r;
  assign out_chan.span_height = out_h_r;
  assign out_chan.span_color  = out_color_r;
  assign out_chan.last        = out_last_r;

endmodule

/* rtl/core/filled_circle_span_rasterizer.sv */
// Top level of the filled circle span rasterizer: front end, job queue, back end.
// Depends on fcsr_pkg, fcsr_ifs, fcsr_front, fcsr_queue and fcsr_back.
//
// Start and step commands enter on in_chan and are accepted one per cycle while
// the two-entry job queue has room; the front end updates the circle walk at
// accept time and queues one job per command. The back end clips a job's spans as
// it takes the job from the queue, then drives one result per cycle from its output
// register while the receiver is ready: one per visible span (up to four), else one,
// and the number of results per command sets the sustained rate. The first result
// of a command passes the queue entry, the work register and the output register.
// Every command yields at least one result; the final one carries last.
// Spans are clipped to SCREEN_WIDTH by SCREEN_HEIGHT. No clearing pass after reset.
module filled_circle_span_rasterizer #(
  parameter int SCREEN_WIDTH  = fcsr_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = fcsr_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  fcsr_in_if.sink    in_chan,
  fcsr_out_if.source out_chan
);

  logic           push, q_full, pop, head_valid;
  fcsr_pkg::job_t push_job, head_job;

  fcsr_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .q_full  (q_full),
    .push    (push),
    .job     (push_job)
  );

  fcsr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_job   (push_job),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  fcsr_back #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (head_valid),
    .job       (head_job),
    .pop       (pop),
    .out_chan  (out_chan)
  );

endmodule

/* rtl/core/fcsr_checker.sv */
// Port-level checks on the result channel of the rasterizer, bound to the top level.
// Depends on fcsr_pkg and filled_circle_span_rasterizer.
module fcsr_checker #(
  parameter int SCREEN_WIDTH  = fcsr_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = fcsr_pkg::SCREEN_HEIGHT_DEF
) (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_kind,
  input logic [7:0]  out_span_x,
  input logic [7:0]  out_span_y,
  input logic [7:0]  out_span_height,
  input logic [15:0] out_span_color,
  input logic        out_last
);

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_span_x)
      && $stable(out_span_y) && $stable(out_span_height) && $stable(out_last))
    else $error("stalled result changed");

  a_status_clean: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid && out_kind != fcsr_pkg::KIND_SPAN |-> out_last && out_span_x == 8'd0
      && out_span_y == 8'd0 && out_span_height == 8'd0 && out_span_color == 16'd0)
    else $error("status result not alone or carries span fields");

  a_span_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid && out_kind == fcsr_pkg::KIND_SPAN |-> out_span_height != 8'd0
      && int'(out_span_x) < SCREEN_WIDTH && int'(out_span_y) < SCREEN_HEIGHT
      && int'(out_span_y) + int'(out_span_height) <= SCREEN_HEIGHT)
    else $error("span outside the screen");

endmodule

bind filled_circle_span_rasterizer fcsr_checker #(
  .SCREEN_WIDTH  (SCREEN_WIDTH),
  .SCREEN_HEIGHT (SCREEN_HEIGHT)
) u_fcsr_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_chan.valid),
  .out_ready       (out_chan.ready),
  .out_kind        (out_chan.kind),
  .out_span_x      (out_chan.span_x),
  .out_span_y      (out_chan.span_y),
  .out_span_height (out_chan.span_height),
  .out_span_color  (out_chan.span_color),
  .out_last        (out_chan.last)
);

/* bench/testbench.sv */
// Self-checking bench for filled_circle_span_rasterizer: directed and random circle commands.
// Predicts every span result in-line and checks each one; depends on fcsr_pkg and fcsr_ifs.
`timescale 1ns / 100ps

module testbench;

  typedef struct {
    logic [2:0]  kind;
    logic [7:0]  sx;
    logic [7:0]  sy;
    logic [7:0]  sh;
    logic [15:0] col;
    logic        last;
  } span_result_t;

  logic clk;
  logic rst_n;

  fcsr_in_if  in_chan ();
  fcsr_out_if out_chan ();

  filled_circle_span_rasterizer dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // predicted circle walk
  logic               circle_on;
  logic               center_done;
  logic [7:0]         walk_cx;
  logic [7:0]         walk_cy;
  logic [7:0]         walk_r;
  logic [15:0]        walk_color;
  logic [7:0]         walk_x;
  logic [7:0]         walk_y;
  logic signed [11:0] walk_dec;

  span_result_t pending_results[$];
  span_result_t step_results[$];
  span_result_t exp_r;

  int mismatches;
  int sent_items;
  int result_count;
  int kind_seen[5];
  int burst_left;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  // receiver stall pattern: the mode is picked anew when its random hold count runs out
  initial begin
    int mode;
    int mode_left;
    int stall_left;
    int phase;
    mode = 0;
    mode_left = 100;
    stall_left = 0;
    phase = 0;
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (mode_left == 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(64, 256);
      end else begin
        mode_left--;
      end
      phase++;
      case (mode)
        0: out_chan.ready <= 1'b1;
        1: out_chan.ready <= ($urandom_range(0, 3) != 0);
        2: out_chan.ready <= (phase % 4 == 0);
        default: begin
          if (stall_left > 0) begin
            stall_left--;
            out_chan.ready <= 1'b0;
          end else if ($urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 7);
            out_chan.ready <= 1'b0;
          end else begin
            out_chan.ready <= 1'b1;
          end
        end
      endcase
    end
  end

  function automatic void add_span(input int x, input int y, input int h);
    span_result_t r;
    if (h <= 0) return;
    if (x < 0 || x >= 160) return;
    if (y < 0) begin
      h = h + y;
      y = 0;
    end
    if (y >= 80) return;
    if (y + h > 80) h = 80 - y;
    if (h <= 0 || step_results.size() >= 4) return;
    r.kind = fcsr_pkg::KIND_SPAN;
    r.sx   = x[7:0];
    r.sy   = y[7:0];
    r.sh   = h[7:0];
    r.col  = walk_color;
    r.last = 1'b0;
    step_results.push_back(r);
  endfunction

  function automatic void add_code(input logic [2:0] kind);
    span_result_t r;
    r.kind = kind;
    r.sx   = 8'd0;
    r.sy   = 8'd0;
    r.sh   = 8'd0;
    r.col  = 16'd0;
    r.last = 1'b0;
    step_results.push_back(r);
  endfunction

  function automatic void predict_command(input logic act, input logic [7:0] cx,
                                          input logic [7:0] cy, input logic [7:0] r,
                                          input logic [15:0] col);
    int x;
    int y;
    int d;
    int ccx;
    int ccy;
    step_results.delete();
    ccx = int'(walk_cx);
    ccy = int'(walk_cy);
    if (act == fcsr_pkg::ACT_START) begin
      if (r == 8'd0) begin
        add_code(fcsr_pkg::KIND_REJECTED);
      end else begin
        walk_cx     = cx;
        walk_cy     = cy;
        walk_r      = r;
        walk_color  = col;
        walk_x      = 8'd0;
        walk_y      = r;
        d           = 1 - int'(r);
        walk_dec    = d[11:0];
        circle_on   = 1'b1;
        center_done = 1'b0;
        add_code(fcsr_pkg::KIND_STARTED);
      end
    end else if (!circle_on) begin
      add_code(fcsr_pkg::KIND_DONE);
    end else if (!center_done) begin
      center_done = 1'b1;
      add_span(ccx, ccy - int'(walk_r), 2 * int'(walk_r) + 1);
      if (step_results.size() == 0) add_code(fcsr_pkg::KIND_NONE);
    end else begin
      x = int'(walk_x);
      y = int'(walk_y);
      if (x >= y) begin
        circle_on = 1'b0;
        add_code(fcsr_pkg::KIND_DONE);
      end else begin
        d = walk_dec;
        if (d < 0) begin
          d = d + 2 * x + 3;
        end else begin
          d = d + 2 * (x - y) + 5;
          y--;
        end
        x++;
        walk_x   = x[7:0];
        walk_y   = y[7:0];
        walk_dec = d[11:0];
        add_span(ccx + x, ccy - y, 2 * y + 1);
        add_span(ccx - x, ccy - y, 2 * y + 1);
        add_span(ccx + y, ccy - x, 2 * x + 1);
        add_span(ccx - y, ccy - x, 2 * x + 1);
        if (step_results.size() == 0) add_code(fcsr_pkg::KIND_NONE);
      end
    end
    step_results[step_results.size() - 1].last = 1'b1;
    foreach (step_results[i]) pending_results.push_back(step_results[i]);
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) begin
      result_count++;
      if (out_chan.kind < 5) kind_seen[out_chan.kind]++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: kind %0d x %0d y %0d h %0d color %h last %b",
                   out_chan.kind, out_chan.span_x, out_chan.span_y, out_chan.span_height,
                   out_chan.span_color, out_chan.last);
      end else begin
        exp_r = pending_results.pop_front();
        if (out_chan.kind !== exp_r.kind || out_chan.span_x !== exp_r.sx ||
            out_chan.span_y !== exp_r.sy || out_chan.span_height !== exp_r.sh ||
            out_chan.span_color !== exp_r.col || out_chan.last !== exp_r.last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch at %0t: expected kind %0d x %0d y %0d h %0d color %h last %b",
                     $realtime, exp_r.kind, exp_r.sx, exp_r.sy, exp_r.sh, exp_r.col,
                     exp_r.last);
            $display("  got kind %0d x %0d y %0d h %0d color %h last %b",
                     out_chan.kind, out_chan.span_x, out_chan.span_y,
                     out_chan.span_height, out_chan.span_color, out_chan.last);
          end
        end
      end
    end
  end

  task automatic send_cmd(input logic act, input logic [7:0] cx, input logic [7:0] cy,
                          input logic [7:0] r, input logic [15:0] col);
    in_chan.valid      <= 1'b1;
    in_chan.action     <= act;
    in_chan.center_x   <= cx;
    in_chan.center_y   <= cy;
    in_chan.radius     <= r;
    in_chan.fill_color <= col;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    predict_command(act, cx, cy, r, col);
    sent_items++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(0, 12);
    end
  endtask

  task automatic step_cmd();
    send_cmd(fcsr_pkg::ACT_STEP, 8'($urandom), 8'($urandom), 8'($urandom), 16'($urandom));
  endtask

  // hold off the sender until every predicted result has arrived
  task automatic wait_drained();
    in_chan.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic test_idle_commands();
    step_cmd();
    send_cmd(fcsr_pkg::ACT_START, 8'd10, 8'd10, 8'd0, 16'hFFFF);
  endtask

  task automatic test_small_circle();
    send_cmd(fcsr_pkg::ACT_START, 8'd80, 8'd40, 8'd1, 16'hFFFF);
    repeat (4) step_cmd();
  endtask

  task automatic test_clipping();
    send_cmd(fcsr_pkg::ACT_START, 8'd0, 8'd0, 8'd255, 16'h0000);
    repeat (2) step_cmd();
    send_cmd(fcsr_pkg::ACT_START, 8'd255, 8'd255, 8'd3, 16'h5555);
    step_cmd();
    send_cmd(fcsr_pkg::ACT_START, 8'd159, 8'd79, 8'd2, 16'hAAAA);
    repeat (3) step_cmd();
  endtask

  task automatic test_reject_replace();
    send_cmd(fcsr_pkg::ACT_START, 8'd40, 8'd20, 8'd5, 16'h1234);
    step_cmd();
    send_cmd(fcsr_pkg::ACT_START, 8'd1, 8'd2, 8'd0, 16'hEDCB);
    step_cmd();
    send_cmd(fcsr_pkg::ACT_START, 8'd120, 8'd60, 8'd7, 16'hF00F);
    repeat (2) step_cmd();
  endtask

  task automatic test_full_walks(input int item_goal);
    logic [7:0] cx;
    logic [7:0] cy;
    logic [7:0] r;
    int         steps;
    int         step_cap;
    bit         drained;
    drained = 0;
    while (sent_items < item_goal) begin
      if ($urandom_range(0, 3) != 0) begin
        cx = 8'($urandom_range(0, 159));
        cy = 8'($urandom_range(0, 79));
      end else begin
        cx = 8'($urandom);
        cy = 8'($urandom);
      end
      if ($urandom_range(0, 11) == 0) begin
        r = 8'($urandom_range(25, 255));
        step_cap = $urandom_range(2, 8);
      end else begin
        r = 8'($urandom_range(1, 24));
        step_cap = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 5) : 1000;
      end
      send_cmd(fcsr_pkg::ACT_START, cx, cy, r, 16'($urandom));
      steps = 0;
      while (circle_on && steps < step_cap) begin
        if ($urandom_range(0, 15) == 0)
          send_cmd(fcsr_pkg::ACT_START, 8'($urandom), 8'($urandom), 8'd0, 16'($urandom));
        step_cmd();
        steps++;
      end
      if ($urandom_range(0, 3) == 0) step_cmd();
      if (!drained && sent_items > item_goal / 2) begin
        wait_drained();
        drained = 1;
      end
    end
  endtask

  task automatic test_random_mix(input int item_goal);
    logic       act;
    logic [7:0] r;
    while (sent_items < item_goal) begin
      act = ($urandom_range(0, 3) == 0) ? fcsr_pkg::ACT_START : fcsr_pkg::ACT_STEP;
      r = ($urandom_range(0, 7) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
      if (act == fcsr_pkg::ACT_START && r > 8'd40 && $urandom_range(0, 1) == 0)
        r = 8'($urandom_range(1, 40));
      send_cmd(act, 8'($urandom), 8'($urandom), r, 16'($urandom));
    end
  endtask

  initial begin
    circle_on   = 1'b0;
    center_done = 1'b0;
    walk_cx     = 8'd0;
    walk_cy     = 8'd0;
    walk_r      = 8'd0;
    walk_color  = 16'd0;
    walk_x      = 8'd0;
    walk_y      = 8'd0;
    walk_dec    = 12'sd0;
    mismatches  = 0;
    sent_items  = 0;
    result_count = 0;
    burst_left  = 0;
    foreach (kind_seen[i]) kind_seen[i] = 0;
    rst_n              <= 1'b0;
    in_chan.valid      <= 1'b0;
    in_chan.action     <= fcsr_pkg::ACT_START;
    in_chan.center_x   <= 8'd0;
    in_chan.center_y   <= 8'd0;
    in_chan.radius     <= 8'd0;
    in_chan.fill_color <= 16'd0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_idle_commands();
    test_small_circle();
    test_clipping();
    test_reject_replace();
    wait_drained();
    test_full_walks(280);
    wait_drained();
    test_random_mix(420);

    in_chan.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("run covered %0d commands and %0d results: %0d spans, %0d empty steps,",
             sent_items, result_count, kind_seen[fcsr_pkg::KIND_SPAN],
             kind_seen[fcsr_pkg::KIND_NONE]);
    $display("  %0d finished, %0d started, %0d rejected; %0d mismatches",
             kind_seen[fcsr_pkg::KIND_DONE], kind_seen[fcsr_pkg::KIND_STARTED],
             kind_seen[fcsr_pkg::KIND_REJECTED], mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
